### design/kptab_pkg.sv
// kptab_pkg: shared constants, command codes, controller states and the
// control/status structs of the keyed point table.
// No dependencies.
package kptab_pkg;

    localparam int ENTRIES_DEF   = 64;
    localparam int KEY_BYTES_DEF = 24;

    localparam int KEY_WORD_W = 64;
    localparam int KEY_WORDS  = 3;
    localparam int VALUE_W    = 32;
    localparam int KIND_W     = 3;
    localparam int STATUS_W   = 2;

    localparam int S_TDATA_W = KEY_WORDS * KEY_WORD_W + VALUE_W;
    localparam int S_TUSER_W = 8;
    localparam int M_TDATA_W = VALUE_W;
    localparam int M_TUSER_W = 8;

    localparam logic [KIND_W-1:0] KIND_INSERT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_QUERY  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_MODIFY = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DELETE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_ERR  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_DRAIN,
        ST_CLEAR,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic cnt_inc;
        logic rd_en;
        logic clr_wr;
        logic commit;
    } kptab_ctl_t;

    typedef struct packed {
        logic op_clear;
        logic op_scan;
        logic scan_end;
        logic sweep_end;
        logic out_free;
    } kptab_sts_t;

endpackage

### design/kptab_ram.sv
// kptab_ram: generic single-write, single-read RAM with registered read.
// No dependencies.
module kptab_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### design/kptab_ctrl.sv
// kptab_ctrl: command sequencer of the keyed point table.
// Depends on kptab_pkg.
module kptab_ctrl import kptab_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  kptab_sts_t sts,
    output kptab_ctl_t ctl
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        ctl        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_INIT: begin
                ctl.clr_wr  = 1'b1;
                ctl.cnt_inc = 1'b1;
                if (sts.sweep_end) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    ctl.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (sts.op_clear) begin
                    state_next = ST_CLEAR;
                end else if (sts.op_scan) begin
                    state_next = ST_SCAN;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_SCAN: begin
                ctl.rd_en   = 1'b1;
                ctl.cnt_inc = 1'b1;
                if (sts.scan_end) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_DONE;
            end
            ST_CLEAR: begin
                ctl.clr_wr  = 1'b1;
                ctl.cnt_inc = 1'b1;
                if (sts.sweep_end) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (sts.out_free) begin
                    ctl.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_INIT;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_scan_runs: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && !sts.scan_end) |=> state_reg == ST_SCAN)
        else $error("scan left before last entry");
    a_done_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && !sts.out_free) |=> state_reg == ST_DONE)
        else $error("result dropped while output busy");
`endif

endmodule

### design/kptab_dp.sv
// kptab_dp: datapath of the keyed point table: command registers, scan
// counter, entry RAM, match/free search and output register.
// Depends on kptab_pkg and kptab_ram.
module kptab_dp import kptab_pkg::*; #(
    parameter int ENTRIES   = ENTRIES_DEF,
    parameter int KEY_BYTES = KEY_BYTES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [S_TUSER_W-1:0] s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [M_TUSER_W-1:0] m_tuser,
    input  kptab_ctl_t           ctl,
    output kptab_sts_t           sts
);

    localparam int SLOTS = 2 * ENTRIES;
    localparam int AW    = $clog2(SLOTS);
    localparam int CW    = $clog2(SLOTS + 1);
    localparam int KW    = KEY_BYTES * 8;
    localparam int EW    = KW + VALUE_W + 1;

    logic [KIND_W-1:0]  kind_reg;
    logic               tsel_reg;
    logic [KW-1:0]      key_reg;
    logic [VALUE_W-1:0] val_reg;
    logic [CW-1:0]      cnt_reg;
    logic               chk_valid_reg;
    logic [AW-1:0]      chk_addr_reg;
    logic               found_reg;
    logic [AW-1:0]      hit_addr_reg;
    logic [VALUE_W-1:0] hit_val_reg;
    logic               free_reg;
    logic [AW-1:0]      free_addr_reg;
    logic               m_valid_reg;
    logic [STATUS_W-1:0] m_status_reg;
    logic [VALUE_W-1:0] m_data_reg;

    logic [KEY_WORDS*KEY_WORD_W-1:0] key_in;
    logic [AW-1:0]       base;
    logic [AW-1:0]       scan_addr;
    logic [EW-1:0]       rd_data;
    logic                ent_valid;
    logic [KW-1:0]       ent_key;
    logic [VALUE_W-1:0]  ent_val;
    logic                hit;
    logic                is_ins, is_qry, is_mod, is_del, is_clr;
    logic                wr_need;
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [EW-1:0]       ram_wdata;
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  read_value;

    assign key_in    = s_tdata[KEY_WORDS*KEY_WORD_W-1:0];
    assign base      = tsel_reg ? AW'(ENTRIES) : '0;
    assign scan_addr = base + cnt_reg[AW-1:0];

    assign ent_valid = rd_data[EW-1];
    assign ent_key   = rd_data[KW+VALUE_W-1:VALUE_W];
    assign ent_val   = rd_data[VALUE_W-1:0];
    assign hit       = chk_valid_reg && ent_valid && (ent_key == key_reg);

    assign is_ins = (kind_reg == KIND_INSERT);
    assign is_qry = (kind_reg == KIND_QUERY);
    assign is_mod = (kind_reg == KIND_MODIFY);
    assign is_del = (kind_reg == KIND_DELETE);
    assign is_clr = (kind_reg == KIND_CLEAR);

    assign wr_need = (is_ins && !found_reg && free_reg) || ((is_mod || is_del) && found_reg);

    assign ram_we    = ctl.clr_wr || (ctl.commit && wr_need);
    assign ram_waddr = ctl.clr_wr ? cnt_reg[AW-1:0] : (is_ins ? free_addr_reg : hit_addr_reg);
    assign ram_wdata = ctl.clr_wr ? '0 : {!is_del, key_reg, val_reg};

    always_comb begin
        if (is_clr) begin
            status = STATUS_OK;
        end else if (is_ins) begin
            status = found_reg ? STATUS_ERR : (free_reg ? STATUS_OK : STATUS_FULL);
        end else if (is_qry || is_mod || is_del) begin
            status = found_reg ? STATUS_OK : STATUS_ERR;
        end else begin
            status = STATUS_ERR;
        end
    end

    assign read_value = (is_qry && found_reg) ? hit_val_reg : '0;

    assign sts.op_clear  = is_clr;
    assign sts.op_scan   = is_ins || is_qry || is_mod || is_del;
    assign sts.scan_end  = (cnt_reg == CW'(ENTRIES - 1));
    assign sts.sweep_end = (cnt_reg == CW'(SLOTS - 1));
    assign sts.out_free  = !m_valid_reg || m_tready;

    kptab_ram #(
        .WIDTH (EW),
        .DEPTH (SLOTS)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ctl.rd_en),
        .raddr (scan_addr),
        .rdata (rd_data)
    );

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg       <= '0;
            chk_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            free_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            chk_valid_reg <= ctl.rd_en;
            if (ctl.load) begin
                cnt_reg   <= '0;
                found_reg <= 1'b0;
                free_reg  <= 1'b0;
            end else begin
                if (ctl.cnt_inc) begin
                    cnt_reg <= cnt_reg + CW'(1);
                end
                if (hit && !found_reg) begin
                    found_reg <= 1'b1;
                end
                if (chk_valid_reg && !ent_valid && !free_reg) begin
                    free_reg <= 1'b1;
                end
            end
            if (ctl.commit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            kind_reg <= s_tuser[KIND_W-1:0];
            tsel_reg <= s_tuser[KIND_W];
            key_reg  <= key_in[KW-1:0];
            val_reg  <= s_tdata[S_TDATA_W-1:KEY_WORDS*KEY_WORD_W];
        end
        chk_addr_reg <= scan_addr;
        if (hit && !found_reg) begin
            hit_addr_reg <= chk_addr_reg;
            hit_val_reg  <= ent_val;
        end
        if (chk_valid_reg && !ent_valid && !free_reg) begin
            free_addr_reg <= chk_addr_reg;
        end
        if (ctl.commit) begin
            m_status_reg <= status;
            m_data_reg   <= read_value;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = {{(M_TUSER_W - STATUS_W){1'b0}}, m_status_reg};

`ifndef NO_ASSERTIONS
    a_no_write_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.rd_en |-> !ram_we)
        else $error("entry written during scan");
    a_hit_in_table: assert property (@(posedge aclk) disable iff (!aresetn)
        found_reg |-> (tsel_reg ? (hit_addr_reg >= AW'(ENTRIES)) : (hit_addr_reg < AW'(ENTRIES))))
        else $error("match outside selected table");
    a_free_in_table: assert property (@(posedge aclk) disable iff (!aresetn)
        free_reg |-> (tsel_reg ? (free_addr_reg >= AW'(ENTRIES)) : (free_addr_reg < AW'(ENTRIES))))
        else $error("free slot outside selected table");
`endif

endmodule

### design/keyed_point_table.sv
// keyed_point_table: top level joining the sequencer and the datapath.
// Depends on kptab_pkg, kptab_ctrl, kptab_dp (and kptab_ram below it).
//
// channel | handshake          | tdata                                   | tuser
// s_      | s_tvalid, s_tready | key_word_0, key_word_1, key_word_2, value | kind, table_select
// m_      | m_tvalid, m_tready | read_value                              | status
//
// Insert/query/modify/delete: linear scan of one table through the single read
// port of the entry RAM. Clear: one RAM row written per cycle. Unused kinds skip
// the scan and return an error status. After reset all 2 * ENTRIES rows are
// swept; s_tready stays low.
// A waiting result in the output register does not block the next item;
// only the following result waits for m_tready.
module keyed_point_table import kptab_pkg::*; #(
    parameter int ENTRIES   = ENTRIES_DEF,
    parameter int KEY_BYTES = KEY_BYTES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // key_word_0, key_word_1, key_word_2, value
    input  logic [S_TUSER_W-1:0] s_tuser,   // kind[2:0], table_select[3], zero
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // read_value
    output logic [M_TUSER_W-1:0] m_tuser    // status[1:0], zero
);

    kptab_ctl_t ctl;
    kptab_sts_t sts;

    kptab_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .ctl      (ctl)
    );

    kptab_dp #(
        .ENTRIES   (ENTRIES),
        .KEY_BYTES (KEY_BYTES)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .ctl      (ctl),
        .sts      (sts)
    );

endmodule
